/* rtl/dec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_pkg
// Shared types, widths and helpers for the disc collision pipeline.
// ----------------------------------------------------------------------------
package dec_pkg;

  localparam int unsigned VelW  = 16;
  localparam int unsigned QuotW = 18;  // |k*d| stays below 2^18 on contact
  localparam int unsigned DenW  = 26;  // |d|^2 <= (r1+r2)^2 < 2^26 on contact
  localparam int unsigned RemW  = 46;
  localparam int unsigned DshW  = DenW + QuotW - 1;

  // values riding alongside the divider
  typedef struct packed {
    logic signed [VelW-1:0] v1x;
    logic signed [VelW-1:0] v1y;
    logic signed [VelW-1:0] v2x;
    logic signed [VelW-1:0] v2y;
    logic                   contact;
    logic                   coincident;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [RemW-1:0]   rem_x;
    logic [RemW-1:0]   rem_y;
    logic [QuotW-1:0]  q_x;
    logic [QuotW-1:0]  q_y;
    logic              neg_x;
    logic              neg_y;
    logic [DshW-1:0]   dsh;
  } div_t;

  function automatic logic signed [VelW-1:0] sat16(input logic signed [19:0] v);
    logic signed [VelW-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[VelW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/dec_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_front
// Differences, squares, dot product, contact test and numerator set-up.
// ----------------------------------------------------------------------------
module dec_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic signed [15:0]  p1x_i,
  input  wire logic signed [15:0]  p1y_i,
  input  wire logic signed [15:0]  p2x_i,
  input  wire logic signed [15:0]  p2y_i,
  input  wire logic signed [15:0]  v1x_i,
  input  wire logic signed [15:0]  v1y_i,
  input  wire logic signed [15:0]  v2x_i,
  input  wire logic signed [15:0]  v2y_i,
  input  wire logic        [11:0]  r1_i,
  input  wire logic        [11:0]  r2_i,
  output logic                     valid_o,
  output dec_pkg::div_t            data_o
);

  logic [4:0] vld_q;

  // stage 1
  logic signed [16:0] dx1_q, dy1_q, dvx1_q, dvy1_q;
  logic        [12:0] rs1_q;
  dec_pkg::side_t     sd1_q;
  // stage 2
  logic signed [33:0] dx2_d, dy2_d, pdx_d, pdy_d;
  logic        [32:0] dx2_q, dy2_q;
  logic signed [33:0] pdx_q, pdy_q;
  logic        [25:0] thr_q;
  logic signed [16:0] dx2s_q, dy2s_q;
  dec_pkg::side_t     sd2_q;
  // stage 3
  logic        [33:0] len2_d;
  logic signed [34:0] dot_d;
  logic        [25:0] len3_q;
  logic signed [31:0] dot3_q;
  logic signed [13:0] dx3_q, dy3_q;
  dec_pkg::side_t     sd3_d;
  dec_pkg::side_t     sd3_q;
  // stage 4
  logic signed [45:0] nx4_q, ny4_q;
  logic        [25:0] den4_q;
  dec_pkg::side_t     sd4_q;
  logic               norm3;
  // stage 5
  logic        [45:0] magx, magy;
  dec_pkg::div_t      d5_q;

  assign dx2_d  = dx1_q * dx1_q;
  assign dy2_d  = dy1_q * dy1_q;
  assign pdx_d  = dvx1_q * dx1_q;
  assign pdy_d  = dvy1_q * dy1_q;
  assign len2_d = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign dot_d  = {pdx_q[33], pdx_q} + {pdy_q[33], pdy_q};
  assign norm3  = sd3_q.contact && !sd3_q.coincident;
  assign magx   = nx4_q[45] ? 46'(-nx4_q) : 46'(nx4_q);
  assign magy   = ny4_q[45] ? 46'(-ny4_q) : 46'(ny4_q);

  always_comb begin
    sd3_d            = sd2_q;
    sd3_d.contact    = len2_d <= {8'b0, thr_q};
    sd3_d.coincident = len2_d == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q  <= {p1x_i[15], p1x_i} - {p2x_i[15], p2x_i};
      dy1_q  <= {p1y_i[15], p1y_i} - {p2y_i[15], p2y_i};
      dvx1_q <= {v1x_i[15], v1x_i} - {v2x_i[15], v2x_i};
      dvy1_q <= {v1y_i[15], v1y_i} - {v2y_i[15], v2y_i};
      rs1_q  <= {1'b0, r1_i} + {1'b0, r2_i};
      sd1_q  <= '{v1x: v1x_i, v1y: v1y_i, v2x: v2x_i, v2y: v2y_i,
                  contact: 1'b0, coincident: 1'b0};

      dx2_q  <= dx2_d[32:0];
      dy2_q  <= dy2_d[32:0];
      pdx_q  <= pdx_d;
      pdy_q  <= pdy_d;
      thr_q  <= rs1_q * rs1_q;
      dx2s_q <= dx1_q;
      dy2s_q <= dy1_q;
      sd2_q  <= sd1_q;

      // only the contact case needs the narrow copies to be exact
      len3_q <= len2_d[25:0];
      dot3_q <= dot_d[31:0];
      dx3_q  <= dx2s_q[13:0];
      dy3_q  <= dy2s_q[13:0];
      sd3_q  <= sd3_d;

      nx4_q  <= dot3_q * dx3_q;
      ny4_q  <= dot3_q * dy3_q;
      den4_q <= norm3 ? len3_q : 26'd1;
      sd4_q  <= sd3_q;

      // round half away from zero: add den/2 to the magnitude
      d5_q.side  <= sd4_q;
      d5_q.rem_x <= magx + {21'b0, den4_q[25:1]};
      d5_q.rem_y <= magy + {21'b0, den4_q[25:1]};
      d5_q.q_x   <= '0;
      d5_q.q_y   <= '0;
      d5_q.neg_x <= nx4_q[45];
      d5_q.neg_y <= ny4_q[45];
      d5_q.dsh   <= {den4_q, {(dec_pkg::QuotW-1){1'b0}}};
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = d5_q;

endmodule
`default_nettype wire

/* rtl/dec_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dec_div_cell
// One restoring-division step for both components; yields one quotient bit per component.
// ----------------------------------------------------------------------------
module dec_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  dec_pkg::div_t      data_i,
  output logic               valid_o,
  output dec_pkg::div_t      data_o
);

  logic [dec_pkg::RemW-1:0] dext;
  logic                     bx, by;
  logic                     vld_q;
  dec_pkg::div_t            data_d;
  dec_pkg::div_t            data_q;

  assign dext = {{(dec_pkg::RemW-dec_pkg::DshW){1'b0}}, data_i.dsh};
  assign bx   = data_i.rem_x >= dext;
  assign by   = data_i.rem_y >= dext;

  always_comb begin
    data_d       = data_i;
    data_d.rem_x = bx ? data_i.rem_x - dext : data_i.rem_x;
    data_d.rem_y = by ? data_i.rem_y - dext : data_i.rem_y;
    data_d.q_x   = {data_i.q_x[dec_pkg::QuotW-2:0], bx};
    data_d.q_y   = {data_i.q_y[dec_pkg::QuotW-2:0], by};
    data_d.dsh   = data_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

/* rtl/disc_elastic_collision.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disc_elastic_collision
// Contact test and equal-mass elastic response for a pair of discs (Q.4).
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o, one disc pair per beat (positions,
// velocities, radii). Output channel: out_valid_o / out_ready_i, one beat of
// four new velocities plus the contact and coincident flags per input beat.
// Throughput: one pair per cycle while the output is not stalled. The path
// from input beat to output valid runs through five set-up stages
// (differences, products, contact test, numerator, rounding), a row of 18
// divider cells producing one quotient bit each, and the output register.
// The whole pipeline advances together whenever the output register is
// empty or being read; a stalled receiver holds every stage and drops
// in_ready_o in the same cycle, so nothing is lost. Results leave in order.
// Reset clears all valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module disc_elastic_collision (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] first_pos_x_i,
  input  wire logic signed [15:0] first_pos_y_i,
  input  wire logic signed [15:0] second_pos_x_i,
  input  wire logic signed [15:0] second_pos_y_i,
  input  wire logic signed [15:0] first_vel_x_i,
  input  wire logic signed [15:0] first_vel_y_i,
  input  wire logic signed [15:0] second_vel_x_i,
  input  wire logic signed [15:0] second_vel_y_i,
  input  wire logic        [11:0] first_radius_i,
  input  wire logic        [11:0] second_radius_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [15:0] new_first_vel_x_o,
  output logic signed      [15:0] new_first_vel_y_o,
  output logic signed      [15:0] new_second_vel_x_o,
  output logic signed      [15:0] new_second_vel_y_o,
  output logic                    contact_o,
  output logic                    coincident_o
);

  localparam int unsigned NCell = dec_pkg::QuotW;

  logic                en;
  logic                vld   [NCell+1];
  dec_pkg::div_t       chain [NCell+1];

  dec_pkg::div_t       last;
  logic                upd;
  logic signed [18:0]  cx, cy;
  logic signed [19:0]  n1x, n1y, n2x, n2y;

  logic                out_valid_q;
  logic signed [15:0]  n1x_q, n1y_q, n2x_q, n2y_q;
  logic                contact_q, coincident_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  dec_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .p1x_i   (first_pos_x_i),
    .p1y_i   (first_pos_y_i),
    .p2x_i   (second_pos_x_i),
    .p2y_i   (second_pos_y_i),
    .v1x_i   (first_vel_x_i),
    .v1y_i   (first_vel_y_i),
    .v2x_i   (second_vel_x_i),
    .v2y_i   (second_vel_y_i),
    .r1_i    (first_radius_i),
    .r2_i    (second_radius_i),
    .valid_o (vld[0]),
    .data_o  (chain[0])
  );

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    dec_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .data_i  (chain[g]),
      .valid_o (vld[g+1]),
      .data_o  (chain[g+1])
    );
  end

  assign last = chain[NCell];
  assign upd  = last.side.contact && !last.side.coincident;
  assign cx   = last.neg_x ? -$signed({1'b0, last.q_x}) : $signed({1'b0, last.q_x});
  assign cy   = last.neg_y ? -$signed({1'b0, last.q_y}) : $signed({1'b0, last.q_y});
  assign n1x  = {{4{last.side.v1x[15]}}, last.side.v1x} - {cx[18], cx};
  assign n1y  = {{4{last.side.v1y[15]}}, last.side.v1y} - {cy[18], cy};
  assign n2x  = {{4{last.side.v2x[15]}}, last.side.v2x} + {cx[18], cx};
  assign n2y  = {{4{last.side.v2y[15]}}, last.side.v2y} + {cy[18], cy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[NCell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1x_q        <= upd ? dec_pkg::sat16(n1x) : last.side.v1x;
      n1y_q        <= upd ? dec_pkg::sat16(n1y) : last.side.v1y;
      n2x_q        <= upd ? dec_pkg::sat16(n2x) : last.side.v2x;
      n2y_q        <= upd ? dec_pkg::sat16(n2y) : last.side.v2y;
      contact_q    <= last.side.contact;
      coincident_q <= last.side.contact && last.side.coincident;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign new_first_vel_x_o  = n1x_q;
  assign new_first_vel_y_o  = n1y_q;
  assign new_second_vel_x_o = n2x_q;
  assign new_second_vel_y_o = n2y_q;
  assign contact_o          = contact_q;
  assign coincident_o       = coincident_q;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the disc collision block: directed and random disc pairs are
// streamed in, each result is compared with an in-bench collision predictor.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic signed [15:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
    logic        [11:0] r1, r2;
  } pair_t;

  typedef struct packed {
    logic signed [15:0] n1x, n1y, n2x, n2y;
    logic               contact, coincident;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  pair_t pair_q = '0;
  logic in_ready_o, out_valid_o;
  resp_t got;

  resp_t expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle = 0;  // percent
  int unsigned recv_idle = 0;
  bit hold_off = 1'b0;

  disc_elastic_collision u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .first_pos_x_i      (pair_q.p1x),
    .first_pos_y_i      (pair_q.p1y),
    .second_pos_x_i     (pair_q.p2x),
    .second_pos_y_i     (pair_q.p2y),
    .first_vel_x_i      (pair_q.v1x),
    .first_vel_y_i      (pair_q.v1y),
    .second_vel_x_i     (pair_q.v2x),
    .second_vel_y_i     (pair_q.v2y),
    .first_radius_i     (pair_q.r1),
    .second_radius_i    (pair_q.r2),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .new_first_vel_x_o  (got.n1x),
    .new_first_vel_y_o  (got.n1y),
    .new_second_vel_x_o (got.n2x),
    .new_second_vel_y_o (got.n2y),
    .contact_o          (got.contact),
    .coincident_o       (got.coincident)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // round to nearest, ties away from zero; den > 0
  function automatic longint rnd_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic resp_t collide(pair_t p);
    resp_t r;
    longint dx, dy, len2, thr, dot, cx, cy;
    longint n1x, n1y, n2x, n2y;
    dx = longint'(p.p1x) - longint'(p.p2x);
    dy = longint'(p.p1y) - longint'(p.p2y);
    len2 = dx * dx + dy * dy;
    thr = (longint'(p.r1) + longint'(p.r2)) * (longint'(p.r1) + longint'(p.r2));
    n1x = p.v1x; n1y = p.v1y; n2x = p.v2x; n2y = p.v2y;
    r.contact = 1'b0;
    r.coincident = 1'b0;
    if (len2 <= thr) begin
      r.contact = 1'b1;
      if (len2 == 0) begin
        r.coincident = 1'b1;
      end else begin
        dot = (longint'(p.v1x) - p.v2x) * dx + (longint'(p.v1y) - p.v2y) * dy;
        cx = rnd_div(dot * dx, len2);
        cy = rnd_div(dot * dy, len2);
        n1x = n1x - cx; n1y = n1y - cy; n2x = n2x + cx; n2y = n2y + cy;
      end
    end
    r.n1x = clamp16(n1x); r.n1y = clamp16(n1y);
    r.n2x = clamp16(n2x); r.n2y = clamp16(n2y);
    return r;
  endfunction

  task automatic report(string what, longint act, longint exp);
    errors++;
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, act, exp, cycles);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result beat (cycle %0d)", cycles);
      end else begin
        e = expected_q.pop_front();
        if (got.n1x !== e.n1x) report("new_first_vel_x", got.n1x, e.n1x);
        if (got.n1y !== e.n1y) report("new_first_vel_y", got.n1y, e.n1y);
        if (got.n2x !== e.n2x) report("new_second_vel_x", got.n2x, e.n2x);
        if (got.n2y !== e.n2y) report("new_second_vel_y", got.n2y, e.n2y);
        if (got.contact !== e.contact) report("contact", got.contact, e.contact);
        if (got.coincident !== e.coincident)
          report("coincident", got.coincident, e.coincident);
      end
    end
  end

  // valid drops only when the sender idles, so back-to-back beats
  // never see two updates of in_valid_i at one edge
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pair_q <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(collide(p));
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    int unsigned sel;
    p = pair_t'(152'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    sel = $urandom_range(9);
    if (sel < 6) begin
      // near pair: small offset, often touching
      p.p2x = p.p1x + 16'($signed($urandom_range(512)) - 256);
      p.p2y = p.p1y + 16'($signed($urandom_range(512)) - 256);
      p.r1 = 12'($urandom_range(sel < 2 ? 4095 : 200));
      p.r2 = 12'($urandom_range(sel < 2 ? 4095 : 200));
    end else if (sel == 6) begin
      p.p2x = p.p1x;
      p.p2y = p.p1y;
    end
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    p = '0; send_pair(p);                            // coincident, zero radii
    p.p1x = 16; send_pair(p);                        // zero radii apart
    p.r1 = 8; p.r2 = 8; send_pair(p);                // exactly touching
    p.r2 = 7; send_pair(p);                          // just apart
    p = '0; p.p1x = 16; p.r1 = 16; p.v1x = 16'sh7fff; p.v2x = 16'sh8000;
    send_pair(p);                                    // head-on, swaps extreme velocities
    p.v1x = 16'sh8000; p.v2x = 16'sh7fff; send_pair(p);
    p = '0; p.p1x = 3; p.p1y = 1; p.r1 = 4; p.v1x = 5; p.v2y = -7;
    send_pair(p);                                    // oblique contact, rounding
    p = '0; p.p1x = 16'sh7fff; p.p2x = 16'sh8000; p.p1y = 16'sh8000;
    p.p2y = 16'sh7fff; p.r1 = 12'hfff; p.r2 = 12'hfff; send_pair(p);
    p = '0; p.p1x = 16'sh7fff; p.p1y = 16'sh7fff; p.p2x = 16'sh7000;
    p.p2y = 16'sh7000; p.r1 = 12'hfff; p.r2 = 12'hfff;
    p.v1x = 16'sh8000; p.v1y = 16'sh8000; p.v2x = 16'sh7fff; p.v2y = 16'sh7fff;
    send_pair(p);
    p.p2x = p.p1x; p.p2y = p.p1y; send_pair(p);      // coincident, large v
    p = '1; send_pair(p);
  endtask

  task automatic test_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (n) send_pair(rand_pair());
  endtask

  // receiver blocked long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (120) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (60) send_pair(rand_pair());
    join
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(550, 35, 88);
    test_random(550, 88, 35);
    test_backpressure();
    test_random(500, 0, 0);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
